// File: rtl/i2cse_pkg.sv
package i2cse_pkg;

  localparam logic [7:0] ACK_VAL  = 8'h00;
  localparam logic [7:0] NACK_VAL = 8'hFF;
  localparam logic [7:0] GENERAL_CALL_MASK = 8'hFE;
  localparam logic [7:0] HEADER_SKIP = 8'h06;
  localparam logic [7:0] HEADER_LAST_DEFINED = 8'h03;

  localparam logic [1:0] SDA_KEEP    = 2'd0;
  localparam logic [1:0] SDA_RELEASE = 2'd1;
  localparam logic [1:0] SDA_DRIVE   = 2'd2;

  localparam logic [3:0] BITS_NONE = 4'd0;
  localparam logic [3:0] BITS_ACK  = 4'd1;
  localparam logic [3:0] BITS_BYTE = 4'd8;

  localparam logic [1:0] WRITE_BYTES = 2'd2;

  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 40;

  typedef enum logic [2:0] {
    LS_IDLE    = 3'd0,
    LS_START   = 3'd1,
    LS_ADDR    = 3'd2,
    LS_RELEASE = 3'd3,
    LS_RX      = 3'd4,
    LS_HANDLE  = 3'd5
  } link_state_t;

  typedef enum logic [2:0] {
    HD_ASSIGN = 3'd0,
    HD_PING   = 3'd1,
    HD_WRITE  = 3'd2,
    HD_CLEAR  = 3'd3,
    HD_NONE   = 3'd4,
    HD_UNDEF  = 3'd5
  } header_t;

  typedef struct packed {
    link_state_t link;
    header_t     header;
    logic        substate;
    logic [1:0]  bytes_left;
    logic [7:0]  latched_index;
    logic [7:0]  own_address;
  } engine_state_t;

  typedef struct packed {
    logic [1:0] sda_direction;
    logic       shift_load_valid;
    logic [7:0] shift_load_value;
    logic [3:0] bit_count_load;
    logic       reg_write_strobe;
    logic [7:0] reg_write_index;
    logic [7:0] reg_write_value;
    logic       arbitration_used;
  } result_t;

endpackage

// File: rtl/i2cse_step.sv
module i2cse_step import i2cse_pkg::*; (
  input  engine_state_t state,
  input  logic          kind,
  input  logic [7:0]    shift_byte,
  input  logic          arbitration_won,
  input  logic [7:0]    address_reg_index,
  output engine_state_t state_next,
  output result_t       result
);

  always_comb begin
    engine_state_t s;
    result_t       r;
    header_t       hdr;
    logic [7:0]    mine;
    logic [1:0]    left;
    logic          ack;
    logic          do_reply;
    logic          do_write;
    logic [7:0]    w_index;
    logic [7:0]    w_value;

    s        = state;
    r        = '0;
    hdr      = state.header;
    mine     = '0;
    left     = '0;
    ack      = 1'b0;
    do_reply = 1'b0;
    do_write = 1'b0;
    w_index  = '0;
    w_value  = '0;

    // A start condition aborts whatever transfer was in flight.
    if (kind) begin
      s.link     = LS_START;
      s.header   = HD_NONE;
      s.substate = 1'b0;
    end

    case (s.link)
      LS_START: begin
        r.bit_count_load = BITS_BYTE;
        s.link = LS_ADDR;
      end
      LS_ADDR: begin
        mine = {s.own_address[6:0], shift_byte[0]};
        do_reply = 1'b1;
        if (shift_byte == mine || (shift_byte & GENERAL_CALL_MASK) == 8'h00) begin
          ack    = 1'b1;
          s.link = LS_RX;
        end else begin
          s.link = LS_RELEASE;
        end
      end
      LS_RELEASE: begin
        r.sda_direction = SDA_RELEASE;
        s.link   = LS_IDLE;
        s.header = HD_NONE;
      end
      LS_RX: begin
        r.sda_direction  = SDA_RELEASE;
        r.bit_count_load = BITS_BYTE;
        s.link = LS_HANDLE;
      end
      LS_HANDLE: begin
        if (hdr == HD_NONE) begin
          if (shift_byte <= HEADER_LAST_DEFINED) begin
            hdr = header_t'(shift_byte[2:0]);
          end else if (shift_byte != HEADER_SKIP) begin
            hdr = HD_UNDEF;
          end
        end
        s.header = hdr;
        case (hdr)
          HD_ASSIGN: begin
            do_reply = 1'b1;
            if (!s.substate) begin
              if (s.own_address != 8'h00) begin
                s.link = LS_RELEASE;
              end else begin
                ack        = 1'b1;
                s.link     = LS_RX;
                s.substate = 1'b1;
              end
            end else begin
              r.arbitration_used = 1'b1;
              if (arbitration_won) begin
                do_write = 1'b1;
                w_index  = address_reg_index;
                w_value  = shift_byte;
                ack      = 1'b1;
              end
              s.link     = LS_RELEASE;
              s.substate = 1'b0;
            end
          end
          HD_PING: begin
            do_reply = 1'b1;
            ack      = 1'b1;
            s.link   = LS_RELEASE;
          end
          HD_WRITE: begin
            do_reply = 1'b1;
            ack      = 1'b1;
            if (!s.substate) begin
              s.substate   = 1'b1;
              s.bytes_left = WRITE_BYTES;
              s.link       = LS_RX;
            end else begin
              left = s.bytes_left - 2'd1;
              s.bytes_left = left;
              if (left == 2'd1) begin
                s.latched_index = shift_byte;
                s.link = LS_RX;
              end else if (left == 2'd0) begin
                do_write   = 1'b1;
                w_index    = s.latched_index;
                w_value    = shift_byte;
                s.link     = LS_RELEASE;
                s.substate = 1'b0;
              end
            end
          end
          HD_CLEAR: begin
            do_reply = 1'b1;
            ack      = 1'b1;
            do_write = 1'b1;
            w_index  = address_reg_index;
            w_value  = 8'h00;
            s.link   = LS_RELEASE;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    if (do_reply) begin
      r.sda_direction    = SDA_DRIVE;
      r.shift_load_valid = 1'b1;
      r.shift_load_value = ack ? ACK_VAL : NACK_VAL;
      r.bit_count_load   = BITS_ACK;
    end

    // A write that hits the address register also moves the own address.
    if (do_write) begin
      r.reg_write_strobe = 1'b1;
      r.reg_write_index  = w_index;
      r.reg_write_value  = w_value;
      if (w_index == address_reg_index) begin
        s.own_address = w_value;
      end
    end

    state_next = s;
    result     = r;
  end

endmodule

// File: rtl/i2c_slave_command_engine.sv
// I2C slave command engine.
//
// Input channel (s_axis): one item per event from the byte shifter. tuser
// carries the event kind (1 start condition, 0 shift finished); tdata carries
// the byte in the shifter and the random-backoff arbitration flag.
// Output channel (m_axis): exactly one result item per input item: SDA
// direction, ACK/NACK load value, bit count to load, register write strobe
// with index and value, and the arbitration-consumed flag.
// Configuration: cfg_we/cfg_wdata set the register index whose write also
// updates the own slave address; write it only while no item is in flight.
//
// Each result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle unless m_axis stalls; the engine state update
// is a single pass of decode logic feeding the state and result registers.
// Backpressure: while a result waits on m_axis_tready, s_axis_tready stays
// high only if that result is taken in the same cycle, so the single result
// register never overflows and no item is dropped.
// Reset (rst, synchronous): link idle, no header, own address 0, address
// register index 0, output channel empty.
module i2c_slave_command_engine import i2cse_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [7:0] shift_byte, [8] arbitration_won, [15:9] zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [0] kind
  input  logic [0:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [1:0] sda_direction, [2] shift_load_valid, [10:3] shift_load_value,
  // [14:11] bit_count_load, [15] reg_write_strobe, [23:16] reg_write_index,
  // [31:24] reg_write_value, [32] arbitration_used, [39:33] zero
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata
);

  engine_state_t state;
  engine_state_t state_next;
  result_t       step_result;
  result_t       out_result;
  logic [7:0]    address_reg_index;
  logic          accept;

  // Take a new item whenever the result register is empty or being drained.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  i2cse_step u_step (
    .state             (state),
    .kind              (s_axis_tuser[0]),
    .shift_byte        (s_axis_tdata[7:0]),
    .arbitration_won   (s_axis_tdata[8]),
    .address_reg_index (address_reg_index),
    .state_next        (state_next),
    .result            (step_result)
  );

  // Advance the engine state only on an accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.link          <= LS_IDLE;
      state.header        <= HD_NONE;
      state.substate      <= 1'b0;
      state.bytes_left    <= 2'd0;
      state.latched_index <= 8'h00;
      state.own_address   <= 8'h00;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      address_reg_index <= 8'h00;
    end else if (cfg_we) begin
      address_reg_index <= cfg_wdata;
    end
  end

  // Result register: hold while stalled, load on accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_result <= step_result;
    end
  end

  assign m_axis_tdata = {7'd0,
                         out_result.arbitration_used,
                         out_result.reg_write_value,
                         out_result.reg_write_index,
                         out_result.reg_write_strobe,
                         out_result.bit_count_load,
                         out_result.shift_load_value,
                         out_result.shift_load_valid,
                         out_result.sda_direction};

endmodule

// File: rtl/i2cse_checker.sv
module i2cse_checker import i2cse_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  // Output channel is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // An empty result register never refuses an item.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // An ack load always drives SDA for one bit.
  a_ack_shape: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2] |->
      m_axis_tdata[1:0] == SDA_DRIVE && m_axis_tdata[14:11] == BITS_ACK &&
      (m_axis_tdata[10:3] == ACK_VAL || m_axis_tdata[10:3] == NACK_VAL))
    else $error("malformed ack load");

  // Without a strobe the write fields stay zero.
  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[15] |-> m_axis_tdata[31:16] == 16'h0000)
    else $error("write fields set without strobe");

endmodule

bind i2c_slave_command_engine i2cse_checker u_i2cse_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
